### rtl/pef_pkg.sv
package pef_pkg;

   localparam int unsigned DEF_MAX_WINDOW  = 4096;
   localparam int unsigned DEF_SAMPLE_BITS = 16;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam int unsigned COEF_W  = 16;
   localparam int unsigned WL_W    = 13;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   localparam logic [COEF_W-1:0] RST_ATTACK  = 16'd65000;
   localparam logic [COEF_W-1:0] RST_RELEASE = 16'd65500;
   localparam logic [WL_W-1:0]   RST_WINDOW  = 13'd480;

   typedef enum logic [1:0] {
      REG_DETECT_MODE = 2'd0,
      REG_ATTACK      = 2'd1,
      REG_RELEASE     = 2'd2,
      REG_WINDOW      = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_READ,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_SQRT,
      B_MUL1,
      B_MUL2,
      B_OUT
   } back_state_type;

   // smoother settings handed from the register block to the back end
   typedef struct packed {
      logic              detect_mode;
      logic [COEF_W-1:0] attack_coeff;
      logic [COEF_W-1:0] release_coeff;
   } smooth_cfg_type;

endpackage

### rtl/pef_ram.sv
module pef_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/pef_front.sv
module pef_front import pef_pkg::*; #(
   parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int unsigned SUM_W       = 48,
   parameter int unsigned CNT_W       = $clog2(DEF_MAX_WINDOW + 1),
   parameter int unsigned AW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_start,
   input  logic                          req_clear_level,
   input  logic [CNT_W-1:0]              win_len,
   output logic                          ram_re,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [SAMPLE_BITS-1:0]        ram_rdata,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [SAMPLE_BITS-1:0]        ram_wdata,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [SUM_W-1:0]              push_sum,
   output logic [CNT_W-1:0]              push_count,
   output logic [SAMPLE_BITS-1:0]        push_mag,
   output logic                          push_clear
);

   localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

   front_state_type        state_ff, state_in;
   logic [SUM_W-1:0]       sum_ff, sum_in, kept;
   logic [CNT_W-1:0]       seen_ff, seen_in, count_ff, count_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [SAMPLE_BITS-1:0] s_ff, s_mag, old_mag;
   logic                   clear_ff;
   logic [SQ_W-1:0]        osq_ff, sq_ff;
   logic [31:0]            wp32, w32, idx32;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ram_re   = 1'b1;
               state_in = F_READ;
            end
         end
         F_READ: begin
            ram_we   = 1'b1;
            state_in = F_SUM;
         end
         F_SUM: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // oldest sample of the window sits win_len slots behind the write pointer
   assign wp32      = 32'(wp_ff);
   assign w32       = 32'(win_len);
   assign idx32     = (wp32 >= w32) ? (wp32 - w32) : (wp32 + MAX_WINDOW - w32);
   assign ram_raddr = AW'(idx32);
   assign ram_waddr = wp_ff;
   assign ram_wdata = s_ff;
   assign wp_in     = (wp32 + 32'd1 >= MAX_WINDOW) ? '0 : AW'(wp32 + 32'd1);

   assign s_mag   = s_ff[SAMPLE_BITS-1] ? (~s_ff + 1'b1) : s_ff;
   assign old_mag = ram_rdata[SAMPLE_BITS-1] ? (~ram_rdata + 1'b1) : ram_rdata;

   always_comb begin
      if (seen_ff >= win_len) begin
         kept = (sum_ff >= SUM_W'(osq_ff)) ? (sum_ff - SUM_W'(osq_ff)) : '0;
      end else begin
         kept = sum_ff;
      end
      sum_in   = kept + SUM_W'(sq_ff);
      seen_in  = (32'(seen_ff) < MAX_WINDOW) ? (seen_ff + 1'b1) : seen_ff;
      count_in = (seen_in > win_len) ? win_len : seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         sum_ff   <= '0;
         seen_ff  <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (req_valid && req_ready && req_block_start) begin
            sum_ff  <= '0;
            seen_ff <= '0;
         end else if (state_ff == F_SUM) begin
            sum_ff  <= sum_in;
            seen_ff <= seen_in;
            wp_ff   <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s_ff     <= req_sample;
         clear_ff <= req_clear_level;
      end
      if (state_ff == F_READ) begin
         osq_ff <= SQ_W'(old_mag) * SQ_W'(old_mag);
         sq_ff  <= SQ_W'(s_mag) * SQ_W'(s_mag);
      end
      if (state_ff == F_SUM) begin
         count_ff <= count_in;
      end
   end

   assign push_sum   = sum_ff;
   assign push_count = count_ff;
   assign push_mag   = s_mag;
   assign push_clear = clear_ff;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_count != '0) && (push_count <= win_len))
      else $error("window count out of range");

   a_seen_cap: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= MAX_WINDOW)
      else $error("samples seen above window capacity");

endmodule

### rtl/pef_queue.sv
module pef_queue import pef_pkg::*; #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    fill_ff;
   logic             do_push, do_pop;

   assign push_ready = (32'(fill_ff) < DEPTH);
   assign pop_valid  = (fill_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (32'(wr_ff) + 32'd1 >= DEPTH) ? '0 : PW'(32'(wr_ff) + 32'd1);
         end
         if (do_pop) begin
            rd_ff <= (32'(rd_ff) + 32'd1 >= DEPTH) ? '0 : PW'(32'(rd_ff) + 32'd1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= DEPTH)
      else $error("queue overfilled");

endmodule

### rtl/pef_back.sv
module pef_back import pef_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int unsigned SUM_W       = 48,
   parameter int unsigned CNT_W       = $clog2(DEF_MAX_WINDOW + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smooth_cfg_type         cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [SUM_W-1:0]       pop_sum,
   input  logic [CNT_W-1:0]       pop_count,
   input  logic [SAMPLE_BITS-1:0] pop_mag,
   input  logic                   pop_clear,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_envelope,
   output logic [SAMPLE_BITS-1:0] rsp_peak_level
);

   localparam int unsigned LV_W   = SUM_W / 2;
   localparam int unsigned STEP_W = $clog2(SUM_W);
   localparam int unsigned P1_W   = COEF_W + LV_W;
   localparam int unsigned P2_W   = COEF_W + 1 + LV_W;
   localparam int unsigned PS_W   = P2_W + 1;

   back_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [SUM_W-1:0]   dq_ff, dq_in;
   logic [CNT_W-1:0]   rem_ff, rem_in, cnt_ff;
   logic [CNT_W:0]     dtrial;
   logic [LV_W-1:0]    root_ff, root_in;
   logic [LV_W:0]      srem_ff, srem_in;
   logic [LV_W+2:0]    stry, sbase;
   logic [LV_W-1:0]    x_ff, level_ff, peak_ff, level_new;
   logic [COEF_W-1:0]  c_ff, c_sel;
   logic [P1_W-1:0]    p1_ff;
   logic [P2_W-1:0]    p2_ff;
   logic [PS_W-1:0]    psum;
   logic               rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] env_ff, pk_ff;
   logic               out_free, div_last, sqrt_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_last  = (32'(step_ff) == SUM_W - 1);
   assign sqrt_last = (32'(step_ff) == LV_W - 1);

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = cfg.detect_mode ? B_DIV : B_MUL1;
            end
         end
         B_DIV: begin
            if (div_last) begin
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (sqrt_last) begin
               state_in = B_MUL1;
            end
         end
         B_MUL1: begin
            state_in = B_MUL2;
         end
         B_MUL2: begin
            state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // restoring divide, one quotient bit per cycle
   always_comb begin
      dtrial = {rem_ff, dq_ff[SUM_W-1]};
      if (dtrial >= {1'b0, cnt_ff}) begin
         rem_in = CNT_W'(dtrial - {1'b0, cnt_ff});
         dq_in  = {dq_ff[SUM_W-2:0], 1'b1};
      end else begin
         rem_in = CNT_W'(dtrial);
         dq_in  = {dq_ff[SUM_W-2:0], 1'b0};
      end
   end

   // digit-by-digit square root on the quotient, two radicand bits per cycle
   always_comb begin
      sbase = {srem_ff, dq_ff[SUM_W-1:SUM_W-2]};
      stry  = {1'b0, root_ff, 2'b01};
      if (sbase >= stry) begin
         srem_in = (LV_W+1)'(sbase - stry);
         root_in = {root_ff[LV_W-2:0], 1'b1};
      end else begin
         srem_in = (LV_W+1)'(sbase);
         root_in = {root_ff[LV_W-2:0], 1'b0};
      end
   end

   assign c_sel     = (x_ff > level_ff) ? cfg.attack_coeff : cfg.release_coeff;
   assign psum      = PS_W'(p1_ff) + PS_W'(p2_ff);
   assign level_new = LV_W'(psum >> COEF_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         level_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE && pop_valid && pop_clear) begin
            level_ff <= '0;
            peak_ff  <= '0;
         end
         if (state_ff == B_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            level_ff     <= level_new;
            if (level_new > peak_ff) begin
               peak_ff <= level_new;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            dq_ff   <= pop_sum;
            rem_ff  <= '0;
            cnt_ff  <= pop_count;
            step_ff <= '0;
            x_ff    <= LV_W'(pop_mag);
         end
         B_DIV: begin
            dq_ff   <= dq_in;
            rem_ff  <= rem_in;
            step_ff <= div_last ? '0 : step_ff + 1'b1;
            root_ff <= '0;
            srem_ff <= '0;
         end
         B_SQRT: begin
            dq_ff   <= {dq_ff[SUM_W-3:0], 2'b00};
            root_ff <= root_in;
            srem_ff <= srem_in;
            step_ff <= step_ff + 1'b1;
            if (sqrt_last) begin
               x_ff <= root_in;
            end
         end
         B_MUL1: begin
            c_ff  <= c_sel;
            p1_ff <= P1_W'(c_sel) * P1_W'(level_ff);
         end
         B_MUL2: begin
            p2_ff <= P2_W'((COEF_W+1)'(1) << COEF_W) - P2_W'(c_ff) == '0 ? '0 :
                     P2_W'(((COEF_W+1)'(1) << COEF_W) - (COEF_W+1)'(c_ff)) * P2_W'(x_ff);
         end
         B_OUT: begin
            if (out_free) begin
               env_ff <= SAMPLE_BITS'(level_new);
               pk_ff  <= SAMPLE_BITS'((level_new > peak_ff) ? level_new : peak_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_envelope   = env_ff;
   assign rsp_peak_level = pk_ff;

   a_peak_covers_level: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= level_ff)
      else $error("peak below level");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && out_free) |=> rsp_valid && state_ff == B_IDLE)
      else $error("result not presented after smoothing");

endmodule

### rtl/peak_rms_envelope_follower.sv
// Peak / RMS envelope follower, one result item per input item.
// Path from input accept: F_READ, F_SUM and F_PUSH in the front end, the queue, then B_MUL1,
// B_MUL2 and B_OUT in peak mode; RMS mode first runs the bit-serial divider and square root.
// Front and back end each take a new item only when done with the last; the back end also
// waits on rsp_ready and in RMS mode sets the rate; the queue lets the front run ahead.
// Reset (synchronous, active high) clears level, peak, window sum, samples-seen count, write
// pointer, and loads the register defaults; the window memory itself is not cleared.
module peak_rms_envelope_follower import pef_pkg::*; #(
   parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_start,
   input  logic                          req_clear_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SAMPLE_BITS-1:0]        rsp_envelope,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_level,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_AW-1:0]             csr_paddr,
   input  logic [CSR_DW-1:0]             csr_pwdata,
   output logic [CSR_DW-1:0]             csr_prdata,
   output logic                          csr_pready
);

   // sum of squares: 2*SAMPLE_BITS-1 bits per square times the window, plus
   // headroom for a stale sum after window changes; kept even for the root
   localparam int unsigned SUM_W = 2 * ((2 * SAMPLE_BITS + $clog2(MAX_WINDOW) + 5) / 2);
   localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned QW    = SUM_W + CNT_W + SAMPLE_BITS + 1;

   logic              mode_ff;
   logic [COEF_W-1:0] attack_ff, release_ff;
   logic [WL_W-1:0]   wlen_ff;
   logic              csr_wr;
   csr_reg_type       csr_sel;
   logic [31:0]       wl32;
   logic [CNT_W-1:0]  win_len;
   smooth_cfg_type    scfg;

   // ---------------- register block ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         attack_ff  <= RST_ATTACK;
         release_ff <= RST_RELEASE;
         wlen_ff    <= RST_WINDOW;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_DETECT_MODE: mode_ff    <= csr_pwdata[0];
            REG_ATTACK:      attack_ff  <= csr_pwdata[COEF_W-1:0];
            REG_RELEASE:     release_ff <= csr_pwdata[COEF_W-1:0];
            REG_WINDOW:      wlen_ff    <= csr_pwdata[WL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_DETECT_MODE: csr_prdata = CSR_DW'(mode_ff);
         REG_ATTACK:      csr_prdata = CSR_DW'(attack_ff);
         REG_RELEASE:     csr_prdata = CSR_DW'(release_ff);
         REG_WINDOW:      csr_prdata = CSR_DW'(wlen_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // zero window length acts as one, oversize acts as the full memory
   assign wl32    = 32'(wlen_ff);
   assign win_len = (wl32 == 32'd0) ? CNT_W'(1) :
                    (wl32 > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(wl32);

   assign scfg.detect_mode   = mode_ff;
   assign scfg.attack_coeff  = attack_ff;
   assign scfg.release_coeff = release_ff;

   // ---------------- front end: window bookkeeping ----------------
   logic                   ram_re, ram_we;
   logic [AW-1:0]          ram_raddr, ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_rdata, ram_wdata;
   logic                   f_valid, f_ready, f_clear, b_valid, b_ready;
   logic [SUM_W-1:0]       f_sum, b_sum;
   logic [CNT_W-1:0]       f_count, b_count;
   logic [SAMPLE_BITS-1:0] f_mag, b_mag;
   logic                   b_clear;
   logic [QW-1:0]          q_in, q_out;

   pef_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W),
      .AW         (AW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_block_start(req_block_start),
      .req_clear_level(req_clear_level),
      .win_len        (win_len),
      .ram_re         (ram_re),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .push_valid     (f_valid),
      .push_ready     (f_ready),
      .push_sum       (f_sum),
      .push_count     (f_count),
      .push_mag       (f_mag),
      .push_clear     (f_clear)
   );

   // sample history, one entry per window slot
   pef_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_WINDOW),
      .AW   (AW)
   ) u_window (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // ---------------- decoupling queue ----------------
   assign q_in = {f_clear, f_mag, f_count, f_sum};
   assign {b_clear, b_mag, b_count, b_sum} = q_out;

   pef_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (q_in),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_data  (q_out)
   );

   // ---------------- back end: detector and smoother ----------------
   pef_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (scfg),
      .pop_valid     (b_valid),
      .pop_ready     (b_ready),
      .pop_sum       (b_sum),
      .pop_count     (b_count),
      .pop_mag       (b_mag),
      .pop_clear     (b_clear),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_envelope  (rsp_envelope),
      .rsp_peak_level(rsp_peak_level)
   );

endmodule
